// File: sv/zcpg_pkg.sv
// shared constants and types for the zero-cross pattern gate
`default_nettype none
package zcpg_pkg;

  localparam int SAMPLE_WIDTH  = 24;
  localparam int PATTERN_STEPS = 32;
  localparam int STEP_W        = $clog2(PATTERN_STEPS);

  localparam int PERIOD_W  = 24;
  localparam int THRESH_W  = 23;
  localparam int PATTERN_W = 32;
  localparam int LENGTH_W  = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // wide enough for step index + 1 and a clamped length
  localparam int CNT_W = 8;

  localparam logic [PERIOD_W-1:0] ONE_SAMPLE = PERIOD_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD    = 2'd0,
    REG_ZERO_THRESHOLD = 2'd1,
    REG_PATTERN_BITS   = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } cfg_reg_t;

  localparam logic [PERIOD_W-1:0]  RST_STEP_PERIOD    = PERIOD_W'(384000);
  localparam logic [THRESH_W-1:0]  RST_ZERO_THRESHOLD = THRESH_W'(8389);
  localparam logic [PATTERN_W-1:0] RST_PATTERN_BITS   = '1;
  localparam logic [LENGTH_W-1:0]  RST_PATTERN_LENGTH = LENGTH_W'(16);

  // pattern step event for the current item
  typedef struct packed {
    logic fire;
    logic bit_one;
  } step_t;

endpackage
`default_nettype wire

// File: sv/zcpg_if.sv
// stream interfaces for sample items and result items
`default_nettype none
interface zcpg_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] sample_left;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] sample_right;
  logic                                    restart;

  modport source (output valid, sample_left, sample_right, restart, input ready);
  modport sink   (input valid, sample_left, sample_right, restart, output ready);
endinterface

interface zcpg_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] gated_left;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] gated_right;
  logic                                    left_open;
  logic                                    right_open;

  modport source (output valid, gated_left, gated_right, left_open, right_open,
                  input ready);
  modport sink   (input valid, gated_left, gated_right, left_open, right_open,
                  output ready);
endinterface
`default_nettype wire

// File: sv/zcpg_step.sv
// phase accumulator and pattern step sequencer
`default_nettype none
module zcpg_step (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               restart,
  input  wire logic [zcpg_pkg::PERIOD_W-1:0]      step_period,
  input  wire logic [zcpg_pkg::PATTERN_W-1:0]     pattern_bits,
  input  wire logic [zcpg_pkg::LENGTH_W-1:0]      pattern_length,
  output zcpg_pkg::step_t                         step
);

  logic [zcpg_pkg::PERIOD_W-1:0] phase_acc, phase_acc_next;
  logic [zcpg_pkg::STEP_W-1:0]   step_index, step_index_next;

  logic [zcpg_pkg::PERIOD_W-1:0] phase_base;
  logic [zcpg_pkg::STEP_W-1:0]   index_base;
  logic [zcpg_pkg::PERIOD_W-1:0] period_eff;
  logic [zcpg_pkg::PERIOD_W:0]   sum;
  logic [zcpg_pkg::PERIOD_W:0]   diff;
  logic [zcpg_pkg::CNT_W-1:0]    len_eff;
  logic [zcpg_pkg::CNT_W-1:0]    index_inc;
  logic [zcpg_pkg::PATTERN_W-1:0] pattern_shift;

  always_comb begin
    phase_base = restart ? '0 : phase_acc;
    index_base = restart ? '0 : step_index;
    period_eff = (step_period < zcpg_pkg::ONE_SAMPLE) ? zcpg_pkg::ONE_SAMPLE : step_period;
    sum  = {1'b0, phase_base} + {1'b0, zcpg_pkg::ONE_SAMPLE};
    diff = sum - {1'b0, period_eff};
    step.fire = (sum >= {1'b0, period_eff});

    len_eff = (zcpg_pkg::CNT_W'(pattern_length) > zcpg_pkg::CNT_W'(zcpg_pkg::PATTERN_STEPS))
            ? zcpg_pkg::CNT_W'(zcpg_pkg::PATTERN_STEPS)
            : zcpg_pkg::CNT_W'(pattern_length);
    index_inc = zcpg_pkg::CNT_W'(index_base) + zcpg_pkg::CNT_W'(1);

    if (step.fire) begin
      phase_acc_next  = diff[zcpg_pkg::PERIOD_W-1:0];
      step_index_next = (index_inc >= len_eff) ? '0 : index_inc[zcpg_pkg::STEP_W-1:0];
    end else begin
      phase_acc_next  = sum[zcpg_pkg::PERIOD_W-1:0];
      step_index_next = index_base;
    end

    // steps past the top of the pattern word read as zero
    pattern_shift = pattern_bits >> step_index_next;
    step.bit_one  = pattern_shift[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      step_index <= '0;
    end else if (en) begin
      phase_acc  <= phase_acc_next;
      step_index <= step_index_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/zcpg_chan.sv
// per-channel gate with pending open and close flags
`default_nettype none
module zcpg_chan (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire logic                                    restart,
  input  wire logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] sample,
  input  wire logic [zcpg_pkg::THRESH_W-1:0]           zero_threshold,
  input  wire zcpg_pkg::step_t                         step,
  output logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0]      gated,
  output logic                                         open
);

  localparam int CMP_W = zcpg_pkg::SAMPLE_WIDTH + zcpg_pkg::THRESH_W;

  logic gate, gate_next;
  logic arm_open, arm_open_next;
  logic arm_close, arm_close_next;

  logic                                gate_base, open_base, close_base;
  logic [zcpg_pkg::SAMPLE_WIDTH-1:0]   mag;
  logic                                crossing;
  logic                                gate_now, open_now, close_now;

  always_comb begin
    gate_base  = restart ? 1'b0 : gate;
    open_base  = restart ? 1'b0 : arm_open;
    close_base = restart ? 1'b0 : arm_close;

    // the most negative code reads as its unsigned magnitude
    mag = sample[zcpg_pkg::SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;
    crossing = (CMP_W'(mag) < CMP_W'(zero_threshold));

    gate_now  = gate_base;
    open_now  = open_base;
    close_now = close_base;
    if (crossing) begin
      if (open_base) begin
        gate_now = 1'b1;
        open_now = 1'b0;
      end
      if (close_base) begin
        gate_now  = 1'b0;
        close_now = 1'b0;
      end
    end

    gated = gate_now ? sample : '0;
    open  = gate_now;

    gate_next      = gate_now;
    arm_open_next  = open_now;
    arm_close_next = close_now;
    if (step.fire) begin
      if (step.bit_one) begin
        arm_open_next = !gate_now;
      end else begin
        arm_close_next = gate_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate      <= 1'b0;
      arm_open  <= 1'b0;
      arm_close <= 1'b0;
    end else if (en) begin
      gate      <= gate_next;
      arm_open  <= arm_open_next;
      arm_close <= arm_close_next;
    end
  end

`ifndef ASSERT_OFF
  a_open_only_when_closed: assert property (@(posedge clk) disable iff (rst)
    arm_open |-> !gate)
    else $error("open pending on an open gate");
  a_close_only_when_open: assert property (@(posedge clk) disable iff (rst)
    arm_close |-> gate)
    else $error("close pending on a closed gate");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(arm_open && arm_close))
    else $error("open and close pending together");
`endif

endmodule
`default_nettype wire

// File: sv/zero_cross_pattern_gate_top.sv
// top level of the zero-cross pattern gate
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    sample_left, sample_right, restart
//   results   out  valid/ready    gated_left, gated_right, left_open, right_open
//   cfg_*     in   cfg_we         cfg_index, cfg_data (write only)
//
// one item per cycle sustained while results.ready is high; an accepted item is held in the input
// register, then goes through gate and step logic into the result register
// rst is synchronous: gates, pending flags, phase and step index clear,
// registers return to their defaults
// a stalled result holds in place and one more item waits in the input register;
// samples.ready then stays low until results.ready returns
`default_nettype none
module zero_cross_pattern_gate_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  zcpg_in_if.sink                                  samples,
  zcpg_out_if.source                               results,
  input  wire logic                                cfg_we,
  input  wire logic [zcpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [zcpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [zcpg_pkg::PERIOD_W-1:0]  step_period;
  logic [zcpg_pkg::THRESH_W-1:0]  zero_threshold;
  logic [zcpg_pkg::PATTERN_W-1:0] pattern_bits;
  logic [zcpg_pkg::LENGTH_W-1:0]  pattern_length;

  logic                                     s1_valid;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] s1_left, s1_right;
  logic                                     s1_restart;

  logic                                     out_valid;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] out_left, out_right;
  logic                                     out_left_open, out_right_open;

  logic                                     out_free;
  logic                                     advance;
  logic                                     take;
  zcpg_pkg::step_t                          step;
  logic signed [zcpg_pkg::SAMPLE_WIDTH-1:0] left_res, right_res;
  logic                                     left_open_res, right_open_res;

  assign out_free      = !out_valid || results.ready;
  assign advance       = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period    <= zcpg_pkg::RST_STEP_PERIOD;
      zero_threshold <= zcpg_pkg::RST_ZERO_THRESHOLD;
      pattern_bits   <= zcpg_pkg::RST_PATTERN_BITS;
      pattern_length <= zcpg_pkg::RST_PATTERN_LENGTH;
    end else if (cfg_we) begin
      case (zcpg_pkg::cfg_reg_t'(cfg_index))
        zcpg_pkg::REG_STEP_PERIOD:    step_period    <= cfg_data[zcpg_pkg::PERIOD_W-1:0];
        zcpg_pkg::REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[zcpg_pkg::THRESH_W-1:0];
        zcpg_pkg::REG_PATTERN_BITS:   pattern_bits   <= cfg_data[zcpg_pkg::PATTERN_W-1:0];
        zcpg_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[zcpg_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_left    <= samples.sample_left;
      s1_right   <= samples.sample_right;
      s1_restart <= samples.restart;
    end
  end

  zcpg_step u_step (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .restart        (s1_restart),
    .step_period    (step_period),
    .pattern_bits   (pattern_bits),
    .pattern_length (pattern_length),
    .step           (step)
  );

  zcpg_chan u_chan_left (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .restart        (s1_restart),
    .sample         (s1_left),
    .zero_threshold (zero_threshold),
    .step           (step),
    .gated          (left_res),
    .open           (left_open_res)
  );

  zcpg_chan u_chan_right (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .restart        (s1_restart),
    .sample         (s1_right),
    .zero_threshold (zero_threshold),
    .step           (step),
    .gated          (right_res),
    .open           (right_open_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left       <= left_res;
      out_right      <= right_res;
      out_left_open  <= left_open_res;
      out_right_open <= right_open_res;
    end
  end

  assign results.valid       = out_valid;
  assign results.gated_left  = out_left;
  assign results.gated_right = out_right;
  assign results.left_open   = out_left_open;
  assign results.right_open  = out_right_open;

`ifndef ASSERT_OFF
  a_stage_moves_to_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item lost between input and result register");
  a_left_closed_is_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_left_open) |-> (out_left == '0))
    else $error("closed left gate passes a sample");
  a_right_closed_is_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_right_open) |-> (out_right == '0))
    else $error("closed right gate passes a sample");
`endif

endmodule
`default_nettype wire

// File: sim/zero_cross_pattern_gate_top_tb.sv
`timescale 1ns / 1ps
// testbench for the zero-cross pattern gate: predicts every gated sample and checks each result
module zero_cross_pattern_gate_top_tb;
  import zcpg_pkg::*;

  localparam int SW         = SAMPLE_WIDTH;
  localparam int IDLE_LIMIT = 2000;
  localparam int SMP_MIN    = -(1 << (SW - 1));
  localparam int SMP_MAX    = (1 << (SW - 1)) - 1;

  typedef logic signed [SW-1:0] smp_t;

  typedef struct {
    smp_t left;
    smp_t right;
    logic restart;
  } sample_t;

  typedef struct {
    smp_t left;
    smp_t right;
    logic left_open;
    logic right_open;
  } gated_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  zcpg_in_if  samples();
  zcpg_out_if results();

  zero_cross_pattern_gate_top dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .results  (results),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of the registers and the gate state
  logic [PERIOD_W-1:0]  step_period_r;
  logic [THRESH_W-1:0]  threshold_r;
  logic [PATTERN_W-1:0] pattern_r;
  logic [LENGTH_W-1:0]  length_r;
  bit                   gate_st[2];
  bit                   arm_open_st[2];
  bit                   arm_close_st[2];
  int unsigned          phase_st;
  int unsigned          step_st;

  gated_t pending_gated[$];

  int src_idle_max;
  int snk_idle_max;
  int hold_request;
  int failures;
  int samples_sent;
  int results_checked;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_gate_state();
    for (int c = 0; c < 2; c++) begin
      gate_st[c]      = 1'b0;
      arm_open_st[c]  = 1'b0;
      arm_close_st[c] = 1'b0;
    end
    phase_st = 0;
    step_st  = 0;
  endfunction

  // pending flags only act when the magnitude is strictly below the threshold
  function automatic smp_t gate_channel(int c, smp_t v);
    int mag;
    mag = (v < 0) ? -int'(v) : int'(v);
    if (mag < int'(threshold_r)) begin
      if (arm_open_st[c]) begin
        gate_st[c]     = 1'b1;
        arm_open_st[c] = 1'b0;
      end
      if (arm_close_st[c]) begin
        gate_st[c]      = 1'b0;
        arm_close_st[c] = 1'b0;
      end
    end
    return gate_st[c] ? v : '0;
  endfunction

  function automatic gated_t predict_gate(sample_t s);
    gated_t      g;
    int unsigned period;
    int unsigned sum;
    int unsigned len;
    bit          one;
    if (s.restart) clear_gate_state();
    g.left       = gate_channel(0, s.left);
    g.right      = gate_channel(1, s.right);
    g.left_open  = gate_st[0];
    g.right_open = gate_st[1];
    period = (step_period_r < ONE_SAMPLE) ? ONE_SAMPLE : step_period_r;
    sum    = phase_st + ONE_SAMPLE;
    if (sum >= period) begin
      phase_st = sum - period;
      len = (length_r > PATTERN_STEPS) ? PATTERN_STEPS : length_r;
      step_st++;
      if (step_st >= len) step_st = 0;
      one = (step_st < PATTERN_W) && pattern_r[step_st];
      for (int c = 0; c < 2; c++) begin
        if (one) arm_open_st[c] = !gate_st[c];
        else arm_close_st[c] = gate_st[c];
      end
    end else begin
      phase_st = sum;
    end
    phase_st &= 32'hFF_FFFF;
    return g;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STEP_PERIOD:    step_period_r = value[PERIOD_W-1:0];
      REG_ZERO_THRESHOLD: threshold_r   = value[THRESH_W-1:0];
      REG_PATTERN_BITS:   pattern_r     = value[PATTERN_W-1:0];
      REG_PATTERN_LENGTH: length_r      = value[LENGTH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_gate_config(logic [PERIOD_W-1:0] period, logic [THRESH_W-1:0] thresh,
                                 logic [PATTERN_W-1:0] bits, logic [LENGTH_W-1:0] len);
    write_reg(REG_STEP_PERIOD, CFG_DATA_W'(period));
    write_reg(REG_ZERO_THRESHOLD, CFG_DATA_W'(thresh));
    write_reg(REG_PATTERN_BITS, CFG_DATA_W'(bits));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
  endtask

  // valid is left high on return so the next item can follow without a gap
  task automatic send_sample(sample_t s);
    int gap;
    gap = $urandom_range(0, src_idle_max);
    repeat (gap) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid        <= 1'b1;
    samples.sample_left  <= s.left;
    samples.sample_right <= s.right;
    samples.restart      <= s.restart;
    @(posedge clk);
    while (samples.ready !== 1'b1) @(posedge clk);
    pending_gated.push_back(predict_gate(s));
    samples_sent++;
  endtask

  task automatic send_pair(int l, int r, bit rs);
    sample_t s;
    s.left    = l[SW-1:0];
    s.right   = r[SW-1:0];
    s.restart = rs;
    send_sample(s);
  endtask

  task automatic wait_idle();
    samples.valid <= 1'b0;
    while (pending_gated.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // values near the threshold in four picks of ten so crossings happen often
  function automatic smp_t rand_level();
    int pick;
    int m;
    int v;
    pick = $urandom_range(0, 9);
    m = int'(threshold_r) + 2;
    if (pick < 4) begin
      v = int'($urandom_range(0, 2 * m)) - m;
    end else if (pick == 4) begin
      case ($urandom_range(0, 4))
        0: v = SMP_MIN;
        1: v = SMP_MAX;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end else begin
      v = $urandom();
    end
    return v[SW-1:0];
  endfunction

  task automatic send_random(int count, int restart_odds);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      s.left    = rand_level();
      s.right   = rand_level();
      s.restart = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
      send_sample(s);
    end
  endtask

  task automatic test_reset_defaults();
    src_idle_max = 14;
    snk_idle_max = 14;
    send_random(30, 0);
    wait_idle();
  endtask

  task automatic test_crossing_edges();
    src_idle_max = 3;
    snk_idle_max = 3;
    set_gate_config(PERIOD_W'(256), THRESH_W'(8389), 32'hAAAA_AAAA, LENGTH_W'(32));
    send_pair(0, 0, 1'b1);
    send_pair(8388, -8388, 1'b0);
    send_pair(SMP_MAX, SMP_MIN, 1'b0);
    send_pair(8389, -8389, 1'b0);
    send_pair(-1, 1, 1'b0);
    send_pair(SMP_MIN, SMP_MAX, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(SMP_MIN, SMP_MAX, 1'b1);
    send_pair(5, SMP_MIN, 1'b0);
    send_pair(SMP_MAX, 3, 1'b0);
    wait_idle();
  endtask

  task automatic test_threshold_extremes();
    // threshold zero: pending flags never act
    set_gate_config(PERIOD_W'(256), '0, '1, LENGTH_W'(1));
    send_pair(0, 0, 1'b1);
    send_pair(-1, 1, 1'b0);
    send_pair(0, 0, 1'b0);
    wait_idle();
    set_gate_config(PERIOD_W'(256), '1, '1, LENGTH_W'(1));
    send_pair(SMP_MAX, SMP_MIN, 1'b0);
    send_pair(SMP_MAX - 1, SMP_MIN + 1, 1'b0);
    send_pair(SMP_MIN + 1, SMP_MAX - 1, 1'b0);
    wait_idle();
  endtask

  task automatic test_step_limits();
    // period below one sample and zero length
    set_gate_config('0, THRESH_W'(8389), 32'h0000_0001, '0);
    send_pair(0, 0, 1'b1);
    send_pair(100, -100, 1'b0);
    send_pair(SMP_MAX, 0, 1'b0);
    wait_idle();
    // length beyond the pattern size
    set_gate_config(PERIOD_W'(100), THRESH_W'(8389), 32'h8000_0001, LENGTH_W'(63));
    send_pair(0, 0, 1'b0);
    send_pair(1, -1, 1'b0);
    send_pair(-2, 2, 1'b0);
    send_pair(SMP_MIN, 7, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [PERIOD_W-1:0]  period;
    logic [THRESH_W-1:0]  thresh;
    logic [PATTERN_W-1:0] bits;
    logic [LENGTH_W-1:0]  len;
    for (int p = 0; p < 9; p++) begin
      if (p == 2) period = '1;
      else if (p == 3) period = PERIOD_W'(256);
      else if ($urandom_range(0, 3) == 0) period = PERIOD_W'($urandom_range(0, 255));
      else period = PERIOD_W'($urandom_range(256, 256 * 12));
      if (p == 4) thresh = '0;
      else if (p == 5) thresh = '1;
      else if ($urandom_range(0, 3) == 0) thresh = THRESH_W'($urandom());
      else thresh = THRESH_W'($urandom_range(0, 300000));
      if (p == 6) bits = '0;
      else if (p == 7) bits = '1;
      else bits = $urandom();
      if (p == 1) len = LENGTH_W'(32);
      else if (p == 8) len = LENGTH_W'(63);
      else if ($urandom_range(0, 4) == 0) len = LENGTH_W'($urandom_range(0, 63));
      else len = LENGTH_W'($urandom_range(1, 32));
      src_idle_max = (p % 3 == 0 || p == 4) ? 0 : 14;
      snk_idle_max = (p % 3 == 1 || p == 4) ? 0 : 14;
      set_gate_config(period, thresh, bits, len);
      // no restart after the longest period, so the next phase has to catch up
      send_random(75, (p == 2 || p == 3) ? 0 : 50);
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    set_gate_config(PERIOD_W'(512), THRESH_W'(40000), $urandom(), LENGTH_W'(8));
    src_idle_max = 0;
    snk_idle_max = 2;
    hold_request = 300;
    send_random(40, 50);
    wait_idle();
  endtask

  initial begin : result_sink
    int     gap;
    int     hold;
    gated_t exp_g;
    results.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        repeat (hold) begin
          results.ready <= 1'b0;
          @(posedge clk);
        end
      end
      gap = $urandom_range(0, snk_idle_max);
      repeat (gap) begin
        results.ready <= 1'b0;
        @(posedge clk);
      end
      results.ready <= 1'b1;
      @(posedge clk);
      while (results.valid !== 1'b1) @(posedge clk);
      if (pending_gated.size() == 0) begin
        $error("result with no sample waiting: gated_left %0d gated_right %0d",
               results.gated_left, results.gated_right);
        failures++;
      end else begin
        exp_g = pending_gated.pop_front();
        if (results.gated_left !== exp_g.left) begin
          $error("gated_left expected %0d got %0d", exp_g.left, results.gated_left);
          failures++;
        end
        if (results.gated_right !== exp_g.right) begin
          $error("gated_right expected %0d got %0d", exp_g.right, results.gated_right);
          failures++;
        end
        if (results.left_open !== exp_g.left_open) begin
          $error("left_open expected %0b got %0b", exp_g.left_open, results.left_open);
          failures++;
        end
        if (results.right_open !== exp_g.right_open) begin
          $error("right_open expected %0b got %0b", exp_g.right_open, results.right_open);
          failures++;
        end
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 ||
          (samples.valid === 1'b1 && samples.ready === 1'b1) ||
          (results.valid === 1'b1 && results.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_STEP_PERIOD;
    cfg_data             <= '0;
    samples.valid        <= 1'b0;
    samples.sample_left  <= '0;
    samples.sample_right <= '0;
    samples.restart      <= 1'b0;
    src_idle_max    = 0;
    snk_idle_max    = 0;
    hold_request    = 0;
    failures        = 0;
    samples_sent    = 0;
    results_checked = 0;
    reg_writes      = 0;
    step_period_r   = RST_STEP_PERIOD;
    threshold_r     = RST_ZERO_THRESHOLD;
    pattern_r       = RST_PATTERN_BITS;
    length_r        = RST_PATTERN_LENGTH;
    clear_gate_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_crossing_edges();
    test_threshold_extremes();
    test_step_limits();
    test_random_phases();
    test_output_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d samples (restarts, crossings, step wrap, held-off output)",
             samples_sent);
    $display("%0d results checked, %0d register writes", results_checked, reg_writes);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: zero_cross_pattern_gate_top.f
sv/zcpg_pkg.sv
sv/zcpg_if.sv
sv/zcpg_step.sv
sv/zcpg_chan.sv
sv/zero_cross_pattern_gate_top.sv
sim/zero_cross_pattern_gate_top_tb.sv
